### sv/pipc_pkg.sv
// Shared types and constants for the point-in-polygon crossing test.
package pipc_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // one edge, classified and reduced to its differences
  typedef struct packed {
    logic                    en;
    logic                    dy_pos;
    logic signed [DiffW-1:0] dyc;
    logic signed [DiffW-1:0] dxp;
    logic signed [DiffW-1:0] dxc;
    logic signed [DiffW-1:0] dy;
  } edge_t;

  typedef struct packed {
    logic  first;
    logic  last;
    edge_t main_e;
    edge_t close_e;
  } item_t;

  typedef struct packed {
    logic                    en;
    logic                    dy_pos;
    logic signed [ProdW-1:0] lhs;
    logic signed [ProdW-1:0] rhs;
  } prod_t;

endpackage

### sv/pipc_front.sv
// Front end: takes vertices, keeps polygon state and classifies both edges of an item.
module pipc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [pipc_pkg::CoordW-1:0] point_x_i,
  input  logic signed [pipc_pkg::CoordW-1:0] point_y_i,
  input  logic signed [pipc_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [pipc_pkg::CoordW-1:0] vertex_y_i,
  input  logic                                first_vertex_i,
  input  logic                                last_vertex_i,
  input  logic                                push_i,
  output pipc_pkg::item_t                     item_o
);

  logic signed [pipc_pkg::CoordW-1:0] held_px_q, held_py_q, held_px_d, held_py_d;
  logic signed [pipc_pkg::CoordW-1:0] start_x_q, start_y_q, start_x_d, start_y_d;
  logic signed [pipc_pkg::CoordW-1:0] prev_x_q, prev_y_q;

  function automatic pipc_pkg::edge_t classify(
    input logic signed [pipc_pkg::CoordW-1:0] x,
    input logic signed [pipc_pkg::CoordW-1:0] y,
    input logic signed [pipc_pkg::CoordW-1:0] xc,
    input logic signed [pipc_pkg::CoordW-1:0] yc,
    input logic signed [pipc_pkg::CoordW-1:0] xp,
    input logic signed [pipc_pkg::CoordW-1:0] yp,
    input logic                                use_e
  );
    pipc_pkg::edge_t e;
    logic straddle;
    logic x_ok;
    straddle = ((yc < y) && (yp >= y)) || ((yp < y) && (yc >= y));
    x_ok     = (xc <= x) || (xp <= x);
    e.en     = use_e && straddle && x_ok;
    e.dyc    = $signed({y[pipc_pkg::CoordW-1], y}) - $signed({yc[pipc_pkg::CoordW-1], yc});
    e.dxp    = $signed({xp[pipc_pkg::CoordW-1], xp}) - $signed({xc[pipc_pkg::CoordW-1], xc});
    e.dxc    = $signed({x[pipc_pkg::CoordW-1], x}) - $signed({xc[pipc_pkg::CoordW-1], xc});
    e.dy     = $signed({yp[pipc_pkg::CoordW-1], yp}) - $signed({yc[pipc_pkg::CoordW-1], yc});
    e.dy_pos = yp > yc;
    return e;
  endfunction

  always_comb begin
    held_px_d = first_vertex_i ? point_x_i  : held_px_q;
    held_py_d = first_vertex_i ? point_y_i  : held_py_q;
    start_x_d = first_vertex_i ? vertex_x_i : start_x_q;
    start_y_d = first_vertex_i ? vertex_y_i : start_y_q;
    item_o.first   = first_vertex_i;
    item_o.last    = last_vertex_i;
    item_o.main_e  = classify(held_px_d, held_py_d, vertex_x_i, vertex_y_i,
                              prev_x_q, prev_y_q, !first_vertex_i);
    item_o.close_e = classify(held_px_d, held_py_d, start_x_d, start_y_d,
                              vertex_x_i, vertex_y_i, last_vertex_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_px_q <= '0;
      held_py_q <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (push_i) begin
      held_px_q <= held_px_d;
      held_py_q <= held_py_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      prev_x_q  <= vertex_x_i;
      prev_y_q  <= vertex_y_i;
    end
  end

endmodule

### sv/pipc_queue.sv
// Short queue of classified items between front and back.
module pipc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  pipc_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output pipc_pkg::item_t rd_item_o
);

  pipc_pkg::item_t                mem_q [pipc_pkg::QDepth];
  logic [pipc_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [pipc_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           push, pop;

  assign wr_ready_o = cnt_q != pipc_pkg::QCntW'(pipc_pkg::QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + pipc_pkg::QCntW'(1);
    if (pop && !push) cnt_d = cnt_q - pipc_pkg::QCntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == pipc_pkg::QPtrW'(pipc_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == pipc_pkg::QPtrW'(pipc_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

### sv/pipc_back.sv
// Back end: cross-multiplies, compares, accumulates parity and holds the result.
module pipc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  pipc_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            inside_res_o
);

  logic            s1_valid_q;
  logic            s1_first_q, s1_last_q;
  pipc_pkg::prod_t s1_main_q, s1_close_q;
  logic            parity_q, parity_d;
  logic            out_valid_q, out_res_q;
  logic            out_free, adv, load;
  logic            t_main, t_close;

  function automatic pipc_pkg::prod_t mult(input pipc_pkg::edge_t e);
    pipc_pkg::prod_t p;
    p.en     = e.en;
    p.dy_pos = e.dy_pos;
    p.lhs    = e.dyc * e.dxp;
    p.rhs    = e.dxc * e.dy;
    return p;
  endfunction

  function automatic logic toggle(input pipc_pkg::prod_t p);
    return p.en && (p.dy_pos ? (p.lhs < p.rhs) : (p.rhs < p.lhs));
  endfunction

  assign out_free  = !out_valid_q || out_ready_i;
  assign adv       = s1_valid_q && (!s1_last_q || out_free);
  assign load      = !s1_valid_q || adv;
  assign q_ready_o = load;

  assign t_main  = toggle(s1_main_q);
  assign t_close = toggle(s1_close_q);
  assign parity_d = ((s1_first_q ? 1'b0 : parity_q) ^ t_main) ^ (s1_last_q && t_close);

  always_ff @(posedge clk_i) begin
    if (load && q_valid_i) begin
      s1_first_q <= q_item_i.first;
      s1_last_q  <= q_item_i.last;
      s1_main_q  <= mult(q_item_i.main_e);
      s1_close_q <= mult(q_item_i.close_e);
    end
    if (adv && s1_last_q) begin
      out_res_q <= parity_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) s1_valid_q <= q_valid_i;
      if (adv) parity_q <= parity_d;
      if (adv && s1_last_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_res_q;

endmodule

### sv/point_in_polygon_crossing.sv
// Even-odd crossing test of a point against a streamed polygon, one vertex per transfer.
// Once the last vertex is taken it passes through the queue and the multiply stage, then
// is compared into the output register. Throughput: one vertex per cycle, set by the
// two-multiply-per-edge stage, unless a held result output stalls the back end. Reset
// clears point, start, previous vertex and parity to zero and empties the queue.
module point_in_polygon_crossing (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pipc_pkg::CoordW-1:0] point_x_i,
  input  logic signed [pipc_pkg::CoordW-1:0] point_y_i,
  input  logic signed [pipc_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [pipc_pkg::CoordW-1:0] vertex_y_i,
  input  logic                                first_vertex_i,
  input  logic                                last_vertex_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                inside_res_o
);

  pipc_pkg::item_t f_item, q_item;
  logic            push, q_valid, q_ready;

  assign push = in_valid_i && in_ready_o;

  pipc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .push_i         (push),
    .item_o         (f_item)
  );

  pipc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_item_i  (f_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  pipc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_item_i     (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o)
  );

`ifndef SYNTH
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full but reads empty");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !q_ready |=> q_valid && $stable(q_item))
    else $error("queued item lost while back end stalled");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !(q_valid && q_ready) |=> q_valid)
    else $error("accepted vertex did not reach queue");
`endif

endmodule

### tb/sv/tb.sv
// Testbench for point_in_polygon_crossing: streamed polygons checked against an even-odd predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [pipc_pkg::CoordW-1:0] coord_t;
  typedef enum int {SHAPE_LOCAL, SHAPE_GRID, SHAPE_WIDE} shape_e;

  localparam int     ItemTarget  = 1700;
  localparam int     CycleLimit  = 400000;
  localparam int     StallCycles = 300;
  localparam int     MaxReports  = 10;
  localparam coord_t CoordMax    = {1'b0, {(pipc_pkg::CoordW-1){1'b1}}};
  localparam coord_t CoordMin    = {1'b1, {(pipc_pkg::CoordW-1){1'b0}}};

  logic   clk_i          = 1'b0;
  logic   rst_ni         = 1'b0;
  logic   in_valid_i     = 1'b0;
  logic   in_ready_o;
  coord_t point_x_i      = '0;
  coord_t point_y_i      = '0;
  coord_t vertex_x_i     = '0;
  coord_t vertex_y_i     = '0;
  logic   first_vertex_i = 1'b0;
  logic   last_vertex_i  = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i    = 1'b0;
  logic   inside_res_o;

  // predictor state
  coord_t pt_x = '0, pt_y = '0;
  coord_t start_x = '0, start_y = '0;
  coord_t prev_x = '0, prev_y = '0;
  bit     parity = 1'b0;

  bit inside_q[$];
  int errors     = 0;
  int sent_items = 0;
  int cycles     = 0;
  bit steady     = 1'b0;
  int stall_ask  = 0;
  int stall_seen = 0;
  int stall_left = 0;

  point_in_polygon_crossing u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .first_vertex_i (first_vertex_i),
    .last_vertex_i  (last_vertex_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inside_res_o   (inside_res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // edge from (xc,yc) to (xp,yp) against the held point
  function automatic bit crossing_toggle(longint xc, longint yc, longint xp, longint yp);
    longint x, y, dy, lhs, rhs;
    x = pt_x;
    y = pt_y;
    if (!((yc < y && yp >= y) || (yp < y && yc >= y))) return 1'b0;
    if (!(xc <= x || xp <= x)) return 1'b0;
    dy  = yp - yc;
    lhs = (y - yc) * (xp - xc);
    rhs = (x - xc) * dy;
    return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
  endfunction

  task automatic track_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy,
                              bit first, bit last);
    if (first) begin
      pt_x    = px;
      pt_y    = py;
      start_x = vx;
      start_y = vy;
      parity  = 1'b0;
    end else begin
      parity ^= crossing_toggle(vx, vy, prev_x, prev_y);
    end
    prev_x = vx;
    prev_y = vy;
    if (last) begin
      parity ^= crossing_toggle(start_x, start_y, vx, vy);
      inside_q = {inside_q, parity};
    end
  endtask

  task automatic send_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy,
                             bit first, bit last);
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    point_x_i      <= px;
    point_y_i      <= py;
    vertex_x_i     <= vx;
    vertex_y_i     <= vy;
    first_vertex_i <= first;
    last_vertex_i  <= last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    track_vertex(px, py, vx, vy, first, last);
    sent_items++;
  endtask

  // receiver: random stalls, long hold-off on request
  always @(negedge clk_i) begin
    if (stall_ask != stall_seen) begin
      stall_seen = stall_ask;
      stall_left = StallCycles;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (inside_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $display("unexpected result: inside_res=%b", inside_res_o);
      end else begin
        want = inside_q.pop_front();
        if (inside_res_o !== want) begin
          errors++;
          if (errors <= MaxReports)
            $display("inside_res mismatch: expected %b actual %b", want, inside_res_o);
        end
      end
    end
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  task automatic send_polygon(int len, shape_e shape, bit closed);
    coord_t px, py, vx, vy;
    if (shape == SHAPE_WIDE) begin
      px = rand_coord();
      py = rand_coord();
    end else begin
      px = coord_t'(int'($urandom_range(2097151)) - 1048576);
      py = coord_t'(int'($urandom_range(2097151)) - 1048576);
    end
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_LOCAL: begin
          vx = coord_t'(px + int'($urandom_range(4095)) - 2048);
          vy = coord_t'(py + int'($urandom_range(4095)) - 2048);
        end
        SHAPE_GRID: begin
          vx = coord_t'(px + 256 * (int'($urandom_range(6)) - 3));
          vy = coord_t'(py + 256 * (int'($urandom_range(6)) - 3));
        end
        default: begin
          vx = rand_coord();
          vy = rand_coord();
        end
      endcase
      send_vertex((i == 0) ? px : rand_coord(), (i == 0) ? py : rand_coord(), vx, vy,
                  i == 0, closed && i == len - 1);
    end
  endtask

  function automatic shape_e pick_shape();
    int r;
    r = $urandom_range(99);
    return (r < 55) ? SHAPE_LOCAL : (r < 85) ? SHAPE_GRID : SHAPE_WIDE;
  endfunction

  task automatic test_before_first();
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(256), coord_t'(-512), 1'b0, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(-768), coord_t'(512), 1'b0, 1'b1);
  endtask

  task automatic test_single_vertex();
    send_vertex(CoordMax, CoordMin, coord_t'(100), coord_t'(-100), 1'b1, 1'b1);
  endtask

  task automatic test_square();
    for (int k = 0; k < 2; k++) begin
      send_vertex(coord_t'(512 * k), coord_t'(0), coord_t'(-256), coord_t'(-256), 1'b1, 1'b0);
      send_vertex(coord_t'(0), coord_t'(0), coord_t'(256), coord_t'(-256), 1'b0, 1'b0);
      send_vertex(coord_t'(0), coord_t'(0), coord_t'(256), coord_t'(256), 1'b0, 1'b0);
      send_vertex(coord_t'(0), coord_t'(0), coord_t'(-256), coord_t'(256), 1'b0, 1'b1);
    end
  endtask

  task automatic test_extremes();
    send_vertex(coord_t'(0), coord_t'(0), CoordMin, CoordMin, 1'b1, 1'b0);
    send_vertex(CoordMin, CoordMax, CoordMax, CoordMin, 1'b0, 1'b0);
    send_vertex(CoordMax, CoordMin, CoordMax, CoordMax, 1'b0, 1'b0);
    send_vertex(CoordMin, CoordMin, CoordMin, CoordMax, 1'b0, 1'b1);
    send_vertex(coord_t'(CoordMax - 1), coord_t'(0), CoordMin, CoordMin, 1'b1, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), CoordMax, CoordMin, 1'b0, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), CoordMax, CoordMax, 1'b0, 1'b1);
  endtask

  // two vertices level with the point
  task automatic test_on_row();
    send_vertex(coord_t'(256), coord_t'(256), coord_t'(0), coord_t'(0), 1'b1, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(512), coord_t'(256), 1'b0, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(256), coord_t'(512), 1'b0, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(256), 1'b0, 1'b1);
  endtask

  task automatic test_continue_after_last();
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(-512), coord_t'(0), 1'b0, 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(-512), 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    stall_ask++;
    for (int i = 0; i < 30; i++) send_polygon(3, SHAPE_LOCAL, 1'b1);
  endtask

  task automatic test_random();
    int pick, len;
    while (sent_items < ItemTarget) begin
      steady = (sent_items >= 700 && sent_items < 950);
      pick = $urandom_range(99);
      len  = ($urandom_range(99) < 5) ? 1 :
             ($urandom_range(49) == 0) ? $urandom_range(9, 30) : $urandom_range(2, 8);
      if (pick < 8)
        send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (pick < 12)
        send_polygon(len, pick_shape(), 1'b0);
      else
        send_polygon(len, pick_shape(), 1'b1);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_before_first();
    test_single_vertex();
    test_square();
    test_extremes();
    test_on_row();
    test_continue_after_last();
    test_backpressure();
    test_random();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (inside_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
